>>> rtl/stereo_volume_ramp_mixer_core_macros.svh
// assertion macros for the stereo volume ramp mixer core
// needs a clock named clk and an active-low reset named rst_n where used
`ifndef STEREO_VOLUME_RAMP_MIXER_CORE_MACROS_SVH
`define STEREO_VOLUME_RAMP_MIXER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SVRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SVRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/svrm_pkg.sv
// shared types, constants, gain curve and mix helper for the volume ramp mixer
// no dependencies
package svrm_pkg;

  // fixed point format of the level and the ramp step
  localparam int FRACTION_BITS = 24;
  localparam int RAMP_SHIFT    = 5;
  localparam int LEVEL_INT_W   = 7;
  localparam int LEVEL_W       = FRACTION_BITS + LEVEL_INT_W + 1;
  localparam int MAG_W         = LEVEL_W - 1;
  localparam int DVD_W         = MAG_W - RAMP_SHIFT;
  localparam int DIV_CNT_W     = $clog2(DVD_W + 1);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int MS_W     = 16;
  localparam int CNT_W    = MS_W + RAMP_SHIFT;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = GAIN_W + 1 + SAMPLE_W;
  localparam int MIX_SHIFT = 15;
  localparam int SCALED_W = PROD_W - MIX_SHIFT;
  localparam int SUM_W    = SCALED_W + 1;

  localparam logic [MS_W-1:0] RAMP_MS_MAX = 16'd60000;
  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 19'sd32767;
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -19'sd32768;

  // stream packing
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam int IN_BASE_L_LSB  = 0;
  localparam int IN_BASE_R_LSB  = 16;
  localparam int IN_MOVIE_L_LSB = 32;
  localparam int IN_MOVIE_R_LSB = 48;
  localparam int IN_TARGET_LSB  = 64;
  localparam int IN_MS_LSB      = 71;
  localparam int IN_USED_W      = 87;
  localparam int USER_FUNC_BIT  = 0;
  localparam int USER_MOVIE_BIT = 1;

  // item kinds carried in tuser
  localparam logic FUNC_PAIR = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic pair_take;
    logic set_take;
    logic gain_en;
    logic mul_l;
    logic mul_r;
    logic fin;
    logic load_step;
  } svrm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic out_free;
  } svrm_status_t;

  // gain curve, index is the integer level
  localparam logic [GAIN_W-1:0] GAIN_CURVE [0:127] = '{
    16'h0000, 16'h0002, 16'h0008, 16'h0012, 16'h0020, 16'h0032, 16'h0049, 16'h0063,
    16'h0082, 16'h00A4, 16'h00CB, 16'h00F5, 16'h0124, 16'h0157, 16'h018E, 16'h01C9,
    16'h0208, 16'h024B, 16'h0292, 16'h02DD, 16'h032C, 16'h037F, 16'h03D7, 16'h0432,
    16'h0492, 16'h04F5, 16'h055D, 16'h05C9, 16'h0638, 16'h06AC, 16'h0724, 16'h07A0,
    16'h0820, 16'h08A4, 16'h092C, 16'h09B8, 16'h0A48, 16'h0ADD, 16'h0B75, 16'h0C12,
    16'h0CB2, 16'h0D57, 16'h0DFF, 16'h0EAC, 16'h0F5D, 16'h1012, 16'h10CA, 16'h1187,
    16'h1248, 16'h130D, 16'h13D7, 16'h14A4, 16'h1575, 16'h164A, 16'h1724, 16'h1801,
    16'h18E3, 16'h19C8, 16'h1AB2, 16'h1BA0, 16'h1C91, 16'h1D87, 16'h1E81, 16'h1F7F,
    16'h2081, 16'h2187, 16'h2291, 16'h239F, 16'h24B2, 16'h25C8, 16'h26E2, 16'h2801,
    16'h2923, 16'h2A4A, 16'h2B75, 16'h2CA3, 16'h2DD6, 16'h2F0D, 16'h3048, 16'h3187,
    16'h32CA, 16'h3411, 16'h355C, 16'h36AB, 16'h37FF, 16'h3956, 16'h3AB1, 16'h3C11,
    16'h3D74, 16'h3EDC, 16'h4048, 16'h41B7, 16'h432B, 16'h44A3, 16'h461F, 16'h479F,
    16'h4923, 16'h4AAB, 16'h4C37, 16'h4DC7, 16'h4F5C, 16'h50F4, 16'h5290, 16'h5431,
    16'h55D6, 16'h577E, 16'h592B, 16'h5ADC, 16'h5C90, 16'h5E49, 16'h6006, 16'h61C7,
    16'h638C, 16'h6555, 16'h6722, 16'h68F4, 16'h6AC9, 16'h6CA2, 16'h6E80, 16'h7061,
    16'h7247, 16'h7430, 16'h761E, 16'h7810, 16'h7A06, 16'h7C00, 16'h7DFE, 16'h8000
  };

  // base plus product scaled down by 2^15 (floor), saturated to 16 bits
  function automatic logic [SAMPLE_W-1:0] sat_mix(input logic signed [SAMPLE_W-1:0] base,
                                                  input logic signed [PROD_W-1:0] prod);
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    sum;
    scaled = prod[PROD_W-1:MIX_SHIFT];
    sum    = SUM_W'(base) + SUM_W'(scaled);
    if (sum > SAMPLE_MAX) begin
      sat_mix = SAMPLE_MAX[SAMPLE_W-1:0];
    end else if (sum < SAMPLE_MIN) begin
      sat_mix = SAMPLE_MIN[SAMPLE_W-1:0];
    end else begin
      sat_mix = sum[SAMPLE_W-1:0];
    end
  endfunction

endpackage

>>> rtl/svrm_ctrl.sv
// sequencing state machine of the volume ramp mixer
// depends on svrm_pkg for the command and status structs
module svrm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_func,
  input  logic                   in_has_movie,
  input  svrm_pkg::svrm_status_t status,
  output logic                   in_tready,
  output svrm_pkg::svrm_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_GAIN  = 6'b000100,
    S_MUL_L = 6'b001000,
    S_MUL_R = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_func == svrm_pkg::FUNC_PAIR) begin
            cmd.pair_take = 1'b1;
            state_nxt     = S_GAIN;
          end else if (in_has_movie) begin
            cmd.set_take = 1'b1;
            if (status.div_needed) begin
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.load_step = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GAIN: begin
        cmd.gain_en = 1'b1;
        state_nxt   = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_l = 1'b1;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_r = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/svrm_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on svrm_pkg for the operand widths
module svrm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [svrm_pkg::DVD_W-1:0]     dividend,
  input  logic [svrm_pkg::MS_W-1:0]      divisor,
  output logic                           done,
  output logic [svrm_pkg::DVD_W-1:0]     quotient
);

  logic [svrm_pkg::DVD_W-1:0]     dvd_r;
  logic [svrm_pkg::MS_W-1:0]      rem_r;
  logic [svrm_pkg::MS_W-1:0]      dsr_r;
  logic [svrm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [svrm_pkg::MS_W:0]        trial;
  logic                           fits;

  // trial subtract of the next partial remainder
  assign trial = {rem_r, dvd_r[svrm_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // operand and remainder shifting, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[svrm_pkg::DVD_W-2:0], fits};
      rem_r <= fits ? svrm_pkg::MS_W'(trial - {1'b0, dsr_r}) : trial[svrm_pkg::MS_W-1:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= svrm_pkg::DIV_CNT_W'(svrm_pkg::DVD_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == svrm_pkg::DIV_CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - svrm_pkg::DIV_CNT_W'(1);
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> rtl/svrm_dp.sv
// datapath: ramp state, step divide, gain lookup, shared multiplier, output register
// depends on svrm_pkg and svrm_div
module svrm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [svrm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [svrm_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  svrm_pkg::svrm_cmd_t                 cmd,
  output svrm_pkg::svrm_status_t              status,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [svrm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SW = svrm_pkg::SAMPLE_W;
  localparam int LW = svrm_pkg::LEVEL_W;
  localparam int FB = svrm_pkg::FRACTION_BITS;

  // input field slices
  logic signed [SW-1:0]                 f_base_l;
  logic signed [SW-1:0]                 f_base_r;
  logic signed [SW-1:0]                 f_movie_l;
  logic signed [SW-1:0]                 f_movie_r;
  logic [svrm_pkg::LEVEL_INT_W-1:0]     f_target;
  logic [svrm_pkg::MS_W-1:0]            f_ms;
  logic                                 f_has_movie;
  logic [svrm_pkg::MS_W-1:0]            ms_clamp;

  assign f_base_l    = in_tdata[svrm_pkg::IN_BASE_L_LSB +: SW];
  assign f_base_r    = in_tdata[svrm_pkg::IN_BASE_R_LSB +: SW];
  assign f_movie_l   = in_tdata[svrm_pkg::IN_MOVIE_L_LSB +: SW];
  assign f_movie_r   = in_tdata[svrm_pkg::IN_MOVIE_R_LSB +: SW];
  assign f_target    = in_tdata[svrm_pkg::IN_TARGET_LSB +: svrm_pkg::LEVEL_INT_W];
  assign f_ms        = in_tdata[svrm_pkg::IN_MS_LSB +: svrm_pkg::MS_W];
  assign f_has_movie = in_tuser[svrm_pkg::USER_MOVIE_BIT];
  assign ms_clamp    = (f_ms > svrm_pkg::RAMP_MS_MAX) ? svrm_pkg::RAMP_MS_MAX : f_ms;

  // ramp state
  logic signed [LW-1:0]                 level_r;
  logic [svrm_pkg::LEVEL_INT_W-1:0]     target_r;
  logic signed [LW-1:0]                 step_r;
  logic [svrm_pkg::CNT_W-1:0]           ramp_left_r;
  logic                                 neg_r;

  // item registers
  logic signed [SW-1:0]                 base_l_r;
  logic signed [SW-1:0]                 base_r_r;
  logic signed [SW-1:0]                 movie_l_r;
  logic signed [SW-1:0]                 movie_r_r;
  logic                                 has_movie_r;
  logic [svrm_pkg::LEVEL_INT_W-1:0]     idx_r;
  logic [svrm_pkg::GAIN_W-1:0]          gain_r;
  logic signed [svrm_pkg::PROD_W-1:0]   prod_r;
  logic [SW-1:0]                        mix_l_r;

  // output register
  logic                                 out_valid_r;
  logic [SW-1:0]                        out_left_r;
  logic [SW-1:0]                        out_right_r;
  logic [svrm_pkg::LEVEL_INT_W-1:0]     out_level_r;

  // step numerator: target minus current level, split into sign and magnitude
  logic signed [LW-1:0]                 new_target_fix;
  logic signed [LW-1:0]                 num;
  logic [LW-1:0]                        num_mag;
  logic [svrm_pkg::DVD_W-1:0]           dividend;
  logic                                 div_start;
  logic                                 div_done;
  logic [svrm_pkg::DVD_W-1:0]           quotient;
  logic signed [LW-1:0]                 q_ext;
  logic signed [LW-1:0]                 cur_target_fix;
  logic [svrm_pkg::LEVEL_INT_W-1:0]     level_idx;
  logic signed [svrm_pkg::GAIN_W:0]     gain_s;

  assign new_target_fix = LW'(f_target) << FB;
  assign cur_target_fix = LW'(target_r) << FB;
  assign num            = new_target_fix - level_r;
  assign num_mag        = num[LW-1] ? -num : num;
  assign dividend       = svrm_pkg::DVD_W'(num_mag[svrm_pkg::MAG_W-1:0] >> svrm_pkg::RAMP_SHIFT);
  assign div_start      = cmd.set_take && (ms_clamp != '0);
  assign q_ext          = LW'(quotient);

  // the level never goes negative in use, a negative one would read as zero
  assign level_idx = level_r[LW-1] ? '0 : level_r[FB +: svrm_pkg::LEVEL_INT_W];
  assign gain_s    = {1'b0, gain_r};

  svrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ms_clamp),
    .done     (div_done),
    .quotient (quotient)
  );

  // ramp state: set command, per-pair advance and step load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      target_r    <= '0;
      step_r      <= '0;
      ramp_left_r <= '0;
      neg_r       <= 1'b0;
    end else begin
      if (cmd.set_take) begin
        target_r <= f_target;
        neg_r    <= num[LW-1];
        if (ms_clamp != '0) begin
          ramp_left_r <= svrm_pkg::CNT_W'(ms_clamp) << svrm_pkg::RAMP_SHIFT;
        end else begin
          ramp_left_r <= '0;
          level_r     <= new_target_fix;
        end
      end else if (cmd.pair_take && f_has_movie) begin
        if (ramp_left_r != '0) begin
          ramp_left_r <= ramp_left_r - svrm_pkg::CNT_W'(1);
          level_r     <= level_r + step_r;
        end else begin
          level_r <= cur_target_fix;
        end
      end
      if (cmd.load_step) begin
        step_r <= neg_r ? -q_ext : q_ext;
      end
    end
  end

  // sample capture, gain lookup and the shared multiplier
  always_ff @(posedge clk) begin
    if (cmd.pair_take) begin
      base_l_r    <= f_base_l;
      base_r_r    <= f_base_r;
      movie_l_r   <= f_movie_l;
      movie_r_r   <= f_movie_r;
      has_movie_r <= f_has_movie;
    end
    if (cmd.gain_en) begin
      idx_r  <= level_idx;
      gain_r <= svrm_pkg::GAIN_CURVE[level_idx];
    end
    if (cmd.mul_l) begin
      prod_r <= svrm_pkg::PROD_W'(gain_s) * svrm_pkg::PROD_W'(movie_l_r);
    end
    if (cmd.mul_r) begin
      mix_l_r <= svrm_pkg::sat_mix(base_l_r, prod_r);
      prod_r  <= svrm_pkg::PROD_W'(gain_s) * svrm_pkg::PROD_W'(movie_r_r);
    end
  end

  // result payload, pairs without movie pass the base through
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_left_r  <= has_movie_r ? mix_l_r : base_l_r;
      out_right_r <= has_movie_r ? svrm_pkg::sat_mix(base_r_r, prod_r) : base_r_r;
      out_level_r <= idx_r;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.div_needed = (ms_clamp != '0);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_level_r, out_right_r, out_left_r};

endmodule

>>> rtl/stereo_volume_ramp_mixer_core.sv
// a sample pair accepted in S_IDLE passes S_GAIN, S_MUL_L and S_MUL_R, and S_FIN loads its result
// into the output register once that is free; no new pair is taken until the controller is back
// in S_IDLE, since the single multiplier is shared by both channels; a set-volume command with a
// non-zero ramp holds the input in S_DIV while the step divider produces one bit per cycle
// zero-ramp and ignored commands stay in S_IDLE; reset (rst_n low, synchronous)
// clears level, target, step and ramp count to zero and empties the output
module stereo_volume_ramp_mixer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // base_left, base_right, movie_left, movie_right, target_level, ramp_ms, pad
  input  logic [svrm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func, has_movie
  input  logic [svrm_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_left, out_right, level_now, pad
  output logic [svrm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  `include "stereo_volume_ramp_mixer_core_macros.svh"

  svrm_pkg::svrm_cmd_t    cmd;
  svrm_pkg::svrm_status_t status;

  svrm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_func      (in_tuser[svrm_pkg::USER_FUNC_BIT]),
    .in_has_movie (in_tuser[svrm_pkg::USER_MOVIE_BIT]),
    .status       (status),
    .in_tready    (in_tready),
    .cmd          (cmd)
  );

  svrm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // checks on the sequencing
  `SVRM_ASSERT_SAME(a_fin_free, cmd.fin, status.out_free, "result loaded over a pending item")
  `SVRM_ASSERT_NEXT(a_pair_busy, in_tvalid && in_tready && cmd.pair_take, !in_tready, "pair accepted while busy")
  `SVRM_ASSERT_SAME(a_step_load, status.div_done, cmd.load_step, "step quotient not taken")
  `SVRM_ASSERT_SAME(a_valid_src, $rose(out_tvalid), $past(cmd.fin), "result without a finished item")

endmodule

>>> sim/tb.sv
// testbench for stereo_volume_ramp_mixer_core: stream driver, random back-pressure
// and a scoreboard that predicts every mixed pair; needs svrm_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
  import svrm_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 440;

  // one input item as seen on the stream
  typedef struct {
    logic               func;
    logic               has_movie;
    logic signed [15:0] base_l;
    logic signed [15:0] base_r;
    logic signed [15:0] movie_l;
    logic signed [15:0] movie_r;
    logic [6:0]         target;
    logic [15:0]        ms;
  } mix_item_t;

  // one mixed pair
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [6:0]  level;
  } mix_result_t;

  // tracks volume state and the mixed pairs still owed by the core
  class mixer_scoreboard;
    localparam int FRAC      = 24;
    localparam int CNT_SHIFT = 5;
    localparam int MS_LIMIT  = 60000;
    localparam int TOP_LEVEL = 127;

    logic [15:0] gain_tab [0:127] = '{
      16'h0000, 16'h0002, 16'h0008, 16'h0012, 16'h0020, 16'h0032, 16'h0049, 16'h0063,
      16'h0082, 16'h00A4, 16'h00CB, 16'h00F5, 16'h0124, 16'h0157, 16'h018E, 16'h01C9,
      16'h0208, 16'h024B, 16'h0292, 16'h02DD, 16'h032C, 16'h037F, 16'h03D7, 16'h0432,
      16'h0492, 16'h04F5, 16'h055D, 16'h05C9, 16'h0638, 16'h06AC, 16'h0724, 16'h07A0,
      16'h0820, 16'h08A4, 16'h092C, 16'h09B8, 16'h0A48, 16'h0ADD, 16'h0B75, 16'h0C12,
      16'h0CB2, 16'h0D57, 16'h0DFF, 16'h0EAC, 16'h0F5D, 16'h1012, 16'h10CA, 16'h1187,
      16'h1248, 16'h130D, 16'h13D7, 16'h14A4, 16'h1575, 16'h164A, 16'h1724, 16'h1801,
      16'h18E3, 16'h19C8, 16'h1AB2, 16'h1BA0, 16'h1C91, 16'h1D87, 16'h1E81, 16'h1F7F,
      16'h2081, 16'h2187, 16'h2291, 16'h239F, 16'h24B2, 16'h25C8, 16'h26E2, 16'h2801,
      16'h2923, 16'h2A4A, 16'h2B75, 16'h2CA3, 16'h2DD6, 16'h2F0D, 16'h3048, 16'h3187,
      16'h32CA, 16'h3411, 16'h355C, 16'h36AB, 16'h37FF, 16'h3956, 16'h3AB1, 16'h3C11,
      16'h3D74, 16'h3EDC, 16'h4048, 16'h41B7, 16'h432B, 16'h44A3, 16'h461F, 16'h479F,
      16'h4923, 16'h4AAB, 16'h4C37, 16'h4DC7, 16'h4F5C, 16'h50F4, 16'h5290, 16'h5431,
      16'h55D6, 16'h577E, 16'h592B, 16'h5ADC, 16'h5C90, 16'h5E49, 16'h6006, 16'h61C7,
      16'h638C, 16'h6555, 16'h6722, 16'h68F4, 16'h6AC9, 16'h6CA2, 16'h6E80, 16'h7061,
      16'h7247, 16'h7430, 16'h761E, 16'h7810, 16'h7A06, 16'h7C00, 16'h7DFE, 16'h8000
    };

    longint      vol_level;
    logic [6:0]  vol_target;
    longint      vol_step;
    int unsigned ramp_count;
    mix_result_t mixes_due [$];
    int          failures;

    function new();
      vol_level  = 0;
      vol_target = '0;
      vol_step   = 0;
      ramp_count = 0;
      failures   = 0;
    endfunction

    function longint target_q();
      return longint'(vol_target) <<< FRAC;
    endfunction

    // integer level, truncated and clamped to the table
    function logic [6:0] level_idx();
      longint whole;
      if (vol_level < 0) return 7'd0;
      whole = vol_level >>> FRAC;
      return (whole > TOP_LEVEL) ? 7'(TOP_LEVEL) : 7'(whole);
    endfunction

    // base plus gain-scaled movie sample, floor shift, saturated
    function logic [15:0] mix_chan(int base, int movie, int gain);
      int sum;
      sum = base + ((gain * movie) >>> 15);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return sum[15:0];
    endfunction

    function void note_item(mix_item_t it);
      int unsigned ms;
      int          gain;
      mix_result_t res;
      // volume commands: no result, ignored without movie
      if (it.func == FUNC_SET) begin
        if (!it.has_movie) return;
        ms = (it.ms > MS_LIMIT) ? MS_LIMIT : it.ms;
        vol_target = it.target;
        if (ms != 0) begin
          ramp_count = ms << CNT_SHIFT;
          vol_step   = (target_q() - vol_level) / longint'(ramp_count);
        end else begin
          ramp_count = 0;
          vol_level  = target_q();
        end
        return;
      end
      // sample pair
      if (it.has_movie) begin
        if (ramp_count != 0) begin
          ramp_count--;
          vol_level += vol_step;
        end else begin
          vol_level = target_q();
        end
        res.level = level_idx();
        gain      = int'(gain_tab[res.level]);
        res.left  = mix_chan(int'(it.base_l), int'(it.movie_l), gain);
        res.right = mix_chan(int'(it.base_r), int'(it.movie_r), gain);
      end else begin
        res.level = level_idx();
        res.left  = it.base_l;
        res.right = it.base_r;
      end
      mixes_due.push_back(res);
    endfunction

    function void check_mix(mix_result_t got);
      mix_result_t exp_r;
      if (mixes_due.size() == 0) begin
        $error("result with nothing outstanding: left %0h right %0h level %0d",
               got.left, got.right, got.level);
        failures++;
        return;
      end
      exp_r = mixes_due.pop_front();
      if (got.left !== exp_r.left) begin
        $error("out_left expected %0d got %0d", $signed(exp_r.left), $signed(got.left));
        failures++;
      end
      if (got.right !== exp_r.right) begin
        $error("out_right expected %0d got %0d", $signed(exp_r.right), $signed(got.right));
        failures++;
      end
      if (got.level !== exp_r.level) begin
        $error("level_now expected %0d got %0d", exp_r.level, got.level);
        failures++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  mixer_scoreboard mixer_sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int stall_left    = 0;
  int cycle_count   = 0;

  stereo_volume_ramp_mixer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      stall_left = HOLD_CYCLES - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: results are checked before the item taken at the same edge is noted
  always @(posedge clk) begin
    mix_item_t   seen;
    mix_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.left  = out_tdata[15:0];
        got.right = out_tdata[31:16];
        got.level = out_tdata[38:32];
        mixer_sb.check_mix(got);
      end
      if (in_tvalid && in_tready) begin
        seen.func      = in_tuser[USER_FUNC_BIT];
        seen.has_movie = in_tuser[USER_MOVIE_BIT];
        seen.base_l    = in_tdata[IN_BASE_L_LSB +: 16];
        seen.base_r    = in_tdata[IN_BASE_R_LSB +: 16];
        seen.movie_l   = in_tdata[IN_MOVIE_L_LSB +: 16];
        seen.movie_r   = in_tdata[IN_MOVIE_R_LSB +: 16];
        seen.target    = in_tdata[IN_TARGET_LSB +: 7];
        seen.ms        = in_tdata[IN_MS_LSB +: 16];
        mixer_sb.note_item(seen);
      end
    end
  end

  // offer one item from a falling edge and hold it until taken
  task automatic send_item(input mix_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {1'b0, it.ms, it.target, it.movie_r, it.movie_l, it.base_r, it.base_l};
    in_tuser  = {it.has_movie, it.func};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic func, input logic movie,
                             input int bl, input int br, input int ml, input int mr,
                             input int tgt, input int ms);
    mix_item_t it;
    it.func      = func;
    it.has_movie = movie;
    it.base_l    = bl[15:0];
    it.base_r    = br[15:0];
    it.movie_l   = ml[15:0];
    it.movie_r   = mr[15:0];
    it.target    = tgt[6:0];
    it.ms        = ms[15:0];
    send_item(it);
  endtask

  // sample values with the extremes weighted in
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly mixed pairs, some plain pairs, a few volume commands, mostly with short ramps
  function automatic mix_item_t rand_item();
    mix_item_t it;
    int        pick;
    it.base_l  = rand_sample();
    it.base_r  = rand_sample();
    it.movie_l = rand_sample();
    it.movie_r = rand_sample();
    it.target  = 7'($urandom);
    it.ms      = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 4) begin
      it.func      = FUNC_SET;
      it.has_movie = ($urandom_range(9) != 0);
      case ($urandom_range(9))
        0, 1:    it.ms = 16'd0;
        2:       it.ms = 16'($urandom_range(65535, 60000));
        3:       it.ms = 16'($urandom);
        default: it.ms = 16'($urandom_range(3, 1));
      endcase
      case ($urandom_range(7))
        0:       it.target = 7'd0;
        1:       it.target = 7'd127;
        default: it.target = 7'($urandom);
      endcase
    end else begin
      it.func      = FUNC_PAIR;
      it.has_movie = (pick < 85);
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (mixer_sb.mixes_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: gain extremes, saturation, rounding, ignored command, ramp clamp
    send_idle_pct = 36;
    recv_idle_pct = 56;
    send_fields(FUNC_PAIR, 1'b1, 32767, -32768, 32767, -32768, 0, 0);
    send_fields(FUNC_PAIR, 1'b0, -32768, 32767, 0, 0, 127, 65535);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 127, 0);
    send_fields(FUNC_PAIR, 1'b1, 32767, -32768, 32767, -32768, 0, 0);
    send_fields(FUNC_PAIR, 1'b1, 0, 0, -1, 1, 0, 0);
    send_fields(FUNC_PAIR, 1'b1, -32768, 32767, 32767, -32768, 0, 0);
    send_fields(FUNC_SET, 1'b0, 0, 0, 0, 0, 0, 0);
    send_fields(FUNC_PAIR, 1'b1, 1000, -1000, 12345, -12345, 0, 0);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 0, 65535);
    send_fields(FUNC_PAIR, 1'b1, 100, -100, 32767, -32768, 0, 0);
    send_fields(FUNC_PAIR, 1'b0, 5, 6, 32767, 32767, 0, 0);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 64, 60000);
    send_fields(FUNC_PAIR, 1'b1, -7, 7, 20000, -20000, 0, 0);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 3, 1);
    repeat (6) send_fields(FUNC_PAIR, 1'b1, 0, 0, 32767, -32768, 0, 0);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 100, 0);
    send_fields(FUNC_PAIR, 1'b1, 0, 0, 32767, -32768, 0, 0);
    send_fields(FUNC_SET, 1'b1, 0, 0, 0, 0, 0, 0);
    send_fields(FUNC_PAIR, 1'b1, 0, 0, 32767, -32768, 0, 0);

    // random phases with changing idle rates
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (phase == 0 && n == RANDOM_ITEMS / 2) begin
          send_idle_pct = 0;
          hold_requests++;
          repeat (60) send_item(rand_item());
          send_idle_pct = 36;
        end
        send_item(rand_item());
      end
      // sender pause until everything owed has come back
      in_tvalid = 1'b0;
      wait_drained();
    end

    in_tvalid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mixer_sb.failures == 0 && mixer_sb.mixes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
